>>> rtl/sapp_pkg.sv
// shared types and constants for the sequential access prefetch predictor
`timescale 1ns / 1ps
`default_nettype none

package sapp_pkg;

  // most predictions a single access may produce
  localparam int unsigned MaxPred = 32;
  // width of the remaining-prediction counter
  localparam int unsigned CntW    = $clog2(MaxPred + 1);

  localparam int unsigned IdxW    = 32;
  localparam int unsigned DepthW  = 6;
  localparam int unsigned CfgIdxW = 3;
  // shared adder width: holds three times a 32-bit count plus a sign bit
  localparam int unsigned AluW    = 35;

  // output fields: tdata is {run_count, predicted_index}, tuser is {predict_valid, pattern}
  localparam int unsigned OutDataW = 2 * IdxW;
  localparam int unsigned OutUserW = 3;

  typedef enum logic [1:0] {
    PatUnknown = 2'd0,
    PatSeq     = 2'd1,
    PatRandom  = 2'd2,
    PatMixed   = 2'd3
  } pattern_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSeqTh    = 3'd0,
    CfgRandTh   = 3'd1,
    CfgMinObs   = 3'd2,
    CfgDepth    = 3'd3,
    CfgRecLimit = 3'd4
  } cfg_idx_e;

  // reset values of the configuration registers
  localparam logic [IdxW-1:0]   SeqThRst    = 32'd1;
  localparam logic [IdxW-1:0]   RandThRst   = 32'd64;
  localparam logic [IdxW-1:0]   MinObsRst   = 32'd8;
  localparam logic [DepthW-1:0] DepthRst    = 6'd8;
  localparam logic [IdxW-1:0]   RecLimitRst = 32'd0;

endpackage

`default_nettype wire

>>> rtl/sequential_access_prefetch_predictor.sv
// top level of the sequential access prefetch predictor
`timescale 1ns / 1ps
`default_nettype none

// Each input beat carries one accessed record index. The block measures the
// absolute jump from the previous index, bumps a saturating run counter when
// the jump is at most seq_threshold or a saturating random counter when it is
// above random_threshold, then classifies the pattern (unknown, sequential,
// random, mixed). On a sequential pattern it emits one beat per predicted
// index (access_index+1, +2, ... up to predict_depth, capped at 32, and only
// below record_limit); otherwise a single beat with predict_valid low. The
// final beat of each access carries tlast. All arithmetic runs through one
// shared 35-bit add/subtract unit stepped by a small sequencer, which walks
// each access through its states before its first result beat is presented,
// then presents one result per cycle while the consumer keeps tready high.
// Input tready is low from acceptance until the last result is loaded into
// the output register; that register lets the next access enter while the
// final beat still waits. Configuration writes are always ready and must
// only happen while the block is idle.
module sequential_access_prefetch_predictor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream: tdata[31:0] access_index
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [sapp_pkg::IdxW-1:0]     s_axis_tdata,
  // result stream: tdata[31:0] predicted_index, tdata[63:32] run_count
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [sapp_pkg::OutDataW-1:0]      m_axis_tdata,
  // tuser[1:0] pattern, tuser[2] predict_valid
  output logic [sapp_pkg::OutUserW-1:0]      m_axis_tuser,
  output logic                               m_axis_tlast,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sapp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sapp_pkg::IdxW-1:0]     cfg_data_i
);
  import sapp_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StDiff,     // cur - prev
    StNeg,      // prev - cur when the first try went negative
    StCmpSeq,   // seq_threshold - delta
    StIncSeq,
    StCmpRnd,   // random_threshold - delta
    StIncRnd,
    StTotal,    // runs + jumps
    StChkMin,   // total - min_observations
    StTriple,   // 2*jumps + jumps
    StChkSeq,   // 3*jumps - runs
    StChkRnd,   // runs - jumps
    StBase,     // cur + 1
    StRoom,     // record_limit - base
    StEmit
  } state_e;

  // configuration registers
  logic [IdxW-1:0]   seq_th_q, rand_th_q, min_obs_q, rec_limit_q;
  logic [DepthW-1:0] depth_q;

  // sequencer and working registers
  state_e            state_q;
  logic [IdxW-1:0]   prev_q, cur_q, delta_q, seq_runs_q, rand_jumps_q;
  logic              prev_valid_q;
  logic [IdxW:0]     total_q;
  logic [IdxW+1:0]   triple_q;
  logic [IdxW:0]     cand_q;
  logic [CntW-1:0]   cnt_q;
  pattern_e          pat_q;

  // output register
  logic              out_valid_q;
  logic [IdxW-1:0]   out_idx_q, out_run_q;
  logic              out_pv_q, out_last_q;
  pattern_e          out_pat_q;

  // shared add/subtract unit
  logic [AluW-1:0]   alu_a, alu_b, alu_res;
  logic              alu_sub;
  logic              alu_neg;

  logic              in_beat, out_free, out_load;
  logic [DepthW:0]   depth_ext;
  logic [CntW-1:0]   cap;
  logic [CntW-1:0]   room_cnt;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  // a new beat enters the output register
  assign out_load      = (state_q == StEmit) && out_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_run_q, out_idx_q};
  assign m_axis_tuser  = {out_pv_q, out_pat_q};
  assign m_axis_tlast  = out_last_q;

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      StDiff: begin
        alu_a = AluW'(cur_q);  alu_b = AluW'(prev_q);  alu_sub = 1'b1;
      end
      StNeg: begin
        alu_a = AluW'(prev_q); alu_b = AluW'(cur_q);   alu_sub = 1'b1;
      end
      StCmpSeq: begin
        alu_a = AluW'(seq_th_q);  alu_b = AluW'(delta_q); alu_sub = 1'b1;
      end
      StIncSeq: begin
        alu_a = AluW'(seq_runs_q); alu_b = AluW'(1'b1);
      end
      StCmpRnd: begin
        alu_a = AluW'(rand_th_q); alu_b = AluW'(delta_q); alu_sub = 1'b1;
      end
      StIncRnd: begin
        alu_a = AluW'(rand_jumps_q); alu_b = AluW'(1'b1);
      end
      StTotal: begin
        alu_a = AluW'(seq_runs_q); alu_b = AluW'(rand_jumps_q);
      end
      StChkMin: begin
        alu_a = AluW'(total_q); alu_b = AluW'(min_obs_q); alu_sub = 1'b1;
      end
      StTriple: begin
        alu_a = AluW'({rand_jumps_q, 1'b0}); alu_b = AluW'(rand_jumps_q);
      end
      StChkSeq: begin
        alu_a = AluW'(triple_q); alu_b = AluW'(seq_runs_q); alu_sub = 1'b1;
      end
      StChkRnd: begin
        alu_a = AluW'(seq_runs_q); alu_b = AluW'(rand_jumps_q); alu_sub = 1'b1;
      end
      StBase: begin
        alu_a = AluW'(cur_q); alu_b = AluW'(1'b1);
      end
      StRoom: begin
        alu_a = AluW'(rec_limit_q); alu_b = AluW'(cand_q); alu_sub = 1'b1;
      end
      StEmit: begin
        alu_a = AluW'(cand_q); alu_b = AluW'(1'b1);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AluW'(alu_sub);
  assign alu_neg = alu_res[AluW-1];

  // prediction count: depth capped at the hard limit, then at the room left
  assign depth_ext = {1'b0, depth_q};
  assign cap = (depth_ext > (DepthW+1)'(MaxPred)) ? CntW'(MaxPred) : CntW'(depth_ext);
  always_comb begin
    if (alu_res[AluW-1:CntW] != '0) begin
      room_cnt = cap;
    end else if (alu_res[CntW-1:0] < cap) begin
      room_cnt = alu_res[CntW-1:0];
    end else begin
      room_cnt = cap;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_th_q    <= SeqThRst;
      rand_th_q   <= RandThRst;
      min_obs_q   <= MinObsRst;
      depth_q     <= DepthRst;
      rec_limit_q <= RecLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSeqTh:    seq_th_q    <= cfg_data_i;
        CfgRandTh:   rand_th_q   <= cfg_data_i;
        CfgMinObs:   min_obs_q   <= cfg_data_i;
        CfgDepth:    depth_q     <= cfg_data_i[DepthW-1:0];
        CfgRecLimit: rec_limit_q <= cfg_data_i;
        default:     ;  // unused index, write dropped
      endcase
    end
  end

  // sequencer, history, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      cur_q        <= '0;
      delta_q      <= '0;
      seq_runs_q   <= '0;
      rand_jumps_q <= '0;
      total_q      <= '0;
      triple_q     <= '0;
      cand_q       <= '0;
      cnt_q        <= '0;
      pat_q        <= PatUnknown;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_run_q    <= '0;
      out_pv_q     <= 1'b0;
      out_last_q   <= 1'b0;
      out_pat_q    <= PatUnknown;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_beat) begin
            cur_q <= s_axis_tdata;
            if (prev_valid_q) begin
              state_q <= StDiff;
            end else begin
              // first access: no jump to measure
              prev_q       <= s_axis_tdata;
              prev_valid_q <= 1'b1;
              state_q      <= StTotal;
            end
          end
        end
        StDiff: begin
          delta_q <= alu_res[IdxW-1:0];
          state_q <= alu_neg ? StNeg : StCmpSeq;
        end
        StNeg: begin
          delta_q <= alu_res[IdxW-1:0];
          state_q <= StCmpSeq;
        end
        StCmpSeq: begin
          prev_q  <= cur_q;
          state_q <= alu_neg ? StCmpRnd : StIncSeq;
        end
        StIncSeq: begin
          if (!alu_res[IdxW]) begin
            seq_runs_q <= alu_res[IdxW-1:0];
          end
          state_q <= StTotal;
        end
        StCmpRnd: begin
          state_q <= alu_neg ? StIncRnd : StTotal;
        end
        StIncRnd: begin
          if (!alu_res[IdxW]) begin
            rand_jumps_q <= alu_res[IdxW-1:0];
          end
          state_q <= StTotal;
        end
        StTotal: begin
          total_q <= alu_res[IdxW:0];
          state_q <= StChkMin;
        end
        StChkMin: begin
          if (alu_neg) begin
            pat_q   <= PatUnknown;
            cnt_q   <= '0;
            state_q <= StEmit;
          end else begin
            state_q <= StTriple;
          end
        end
        StTriple: begin
          triple_q <= alu_res[IdxW+1:0];
          state_q  <= StChkSeq;
        end
        StChkSeq: begin
          if (alu_neg) begin
            pat_q   <= PatSeq;
            state_q <= StBase;
          end else begin
            state_q <= StChkRnd;
          end
        end
        StChkRnd: begin
          pat_q   <= alu_neg ? PatRandom : PatMixed;
          cnt_q   <= '0;
          state_q <= StEmit;
        end
        StBase: begin
          cand_q  <= alu_res[IdxW:0];
          state_q <= StRoom;
        end
        StRoom: begin
          // limit at or below the first candidate leaves no room
          if (alu_neg || alu_res == '0) begin
            cnt_q <= '0;
          end else begin
            cnt_q <= room_cnt;
          end
          state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            out_pat_q   <= pat_q;
            out_run_q   <= seq_runs_q;
            if (cnt_q == '0) begin
              // single no-prediction beat
              out_pv_q   <= 1'b0;
              out_idx_q  <= '0;
              out_last_q <= 1'b1;
              state_q    <= StIdle;
            end else begin
              out_pv_q   <= 1'b1;
              out_idx_q  <= cand_q[IdxW-1:0];
              out_last_q <= (cnt_q == CntW'(1));
              cand_q     <= alu_res[IdxW:0];
              cnt_q      <= cnt_q - CntW'(1);
              if (cnt_q == CntW'(1)) begin
                state_q <= StIdle;
              end
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/sapp_checker.sv
// port-level checks for the sequential access prefetch predictor
`timescale 1ns / 1ps
`default_nettype none

module sapp_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  input  wire logic                          m_axis_tvalid,
  input  wire logic [sapp_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire logic [sapp_pkg::OutUserW-1:0] m_axis_tuser,
  input  wire logic                          m_axis_tlast
);
  import sapp_pkg::*;

  // an accepted access closes the input side in the cycle after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted access");

  // a beat without a prediction is always the only and last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tlast)
    else $error("no-prediction beat without tlast");

  // a beat without a prediction carries index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[IdxW-1:0] == '0)
    else $error("no-prediction beat with nonzero index");

  // predictions only come with a sequential pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == PatSeq)
    else $error("prediction under a non-sequential pattern");

endmodule

bind sequential_access_prefetch_predictor sapp_checker u_sapp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> tb/prefetch_checker.sv
// checker that predicts and compares the prefetch predictor's result beats
`timescale 1ns / 1ps

module prefetch_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  input  wire logic [sapp_pkg::IdxW-1:0]     s_axis_tdata,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [sapp_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire logic [sapp_pkg::OutUserW-1:0] m_axis_tuser,
  input  wire logic                          m_axis_tlast,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_o,
  input  wire logic [sapp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sapp_pkg::IdxW-1:0]     cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import sapp_pkg::*;

  typedef struct {
    pattern_e        pattern;
    logic            hit;
    logic [IdxW-1:0] index;
    logic [IdxW-1:0] runs;
    logic            last;
  } prediction_t;

  prediction_t expected_predictions[$];

  // mirrored registers
  logic [IdxW-1:0]   seq_th;
  logic [IdxW-1:0]   rand_th;
  logic [IdxW-1:0]   min_obs;
  logic [DepthW-1:0] depth;
  logic [IdxW-1:0]   rec_limit;

  // mirrored history
  logic [IdxW-1:0] prev_idx;
  logic            have_prev;
  logic [IdxW-1:0] run_cnt;
  logic [IdxW-1:0] jump_cnt;

  function automatic pattern_e classify_pattern();
    logic [63:0] total;
    total = {32'b0, run_cnt} + {32'b0, jump_cnt};
    if (total < {32'b0, min_obs}) return PatUnknown;
    if ({32'b0, run_cnt} > {32'b0, jump_cnt} * 64'd3) return PatSeq;
    if (jump_cnt > run_cnt) return PatRandom;
    return PatMixed;
  endfunction

  task automatic predict_access(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] jump;
    logic [63:0]     cand;
    pattern_e        pat;
    int              emitted;
    prediction_t     p;
    if (have_prev) begin
      jump = (idx >= prev_idx) ? idx - prev_idx : prev_idx - idx;
      if (jump <= seq_th) begin
        if (run_cnt != '1) run_cnt = run_cnt + 1;
      end else if (jump > rand_th) begin
        if (jump_cnt != '1) jump_cnt = jump_cnt + 1;
      end
    end
    prev_idx  = idx;
    have_prev = 1'b1;
    pat       = classify_pattern();
    emitted   = 0;
    if (pat == PatSeq) begin
      for (int i = 0; i < int'(depth) && emitted < int'(MaxPred); i++) begin
        cand = {32'b0, idx} + 64'd1 + 64'(i);
        if (cand < {32'b0, rec_limit}) begin
          p.pattern = pat;
          p.hit     = 1'b1;
          p.index   = cand[IdxW-1:0];
          p.runs    = run_cnt;
          p.last    = 1'b0;
          expected_predictions.push_back(p);
          emitted++;
        end
      end
    end
    if (emitted == 0) begin
      p.pattern = pat;
      p.hit     = 1'b0;
      p.index   = '0;
      p.runs    = run_cnt;
      p.last    = 1'b1;
      expected_predictions.push_back(p);
    end else begin
      expected_predictions[$].last = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [IdxW-1:0] exp_v,
                             input logic [IdxW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    prediction_t e;
    if (!rst_ni) begin
      seq_th    = SeqThRst;
      rand_th   = RandThRst;
      min_obs   = MinObsRst;
      depth     = DepthRst;
      rec_limit = RecLimitRst;
      prev_idx  = '0;
      have_prev = 1'b0;
      run_cnt   = '0;
      jump_cnt  = '0;
      expected_predictions.delete();
      pending_o <= 0;
    end else begin
      // results first: they belong to earlier accesses
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_predictions.size() == 0) begin
          $error("result beat with nothing expected: tdata %0h tuser %0h",
                 m_axis_tdata, m_axis_tuser);
          fail_count_o++;
        end else begin
          e = expected_predictions.pop_front();
          check_field("pattern", 32'(e.pattern), 32'(m_axis_tuser[1:0]));
          check_field("predict_valid", 32'(e.hit), 32'(m_axis_tuser[2]));
          check_field("predicted_index", e.index, m_axis_tdata[IdxW-1:0]);
          check_field("run_count", e.runs, m_axis_tdata[OutDataW-1:IdxW]);
          check_field("last", 32'(e.last), 32'(m_axis_tlast));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgSeqTh:    seq_th    = cfg_data_i;
          CfgRandTh:   rand_th   = cfg_data_i;
          CfgMinObs:   min_obs   = cfg_data_i;
          CfgDepth:    depth     = cfg_data_i[DepthW-1:0];
          CfgRecLimit: rec_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_access(s_axis_tdata);
      pending_o <= expected_predictions.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// top of the prefetch predictor testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import sapp_pkg::*;

  // write to an index past the register list, must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd5;
  // watchdog limit in clock cycles, far above the slowest legal run
  localparam int CycleLimit = 200000;
  // cycles of quiet after the last result before a register write or the end
  localparam int SettleCycles = 20;
  // length of the long receiver hold-off
  localparam int HoldCycles = 400;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IdxW-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [IdxW-1:0]     cfg_data_i;

  int fail_count;
  int pending;

  // shared knobs between the sender and the receiver processes
  bit no_idle;
  bit hold_req;

  sequential_access_prefetch_predictor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  prefetch_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // sender keeps offering while this lasts, so the input stalls
        hold_left = HoldCycles - 1;
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  // one access beat; called and returns at a falling edge, leaves tvalid high
  task automatic send_access(input logic [IdxW-1:0] idx);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // one register write; leaves cfg_valid_i high for back-to-back writes
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [IdxW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [IdxW-1:0] seq_th, input logic [IdxW-1:0] rand_th,
                            input logic [IdxW-1:0] min_obs, input logic [IdxW-1:0] depth,
                            input logic [IdxW-1:0] rec_limit);
    cfg_write(CfgSeqTh, seq_th);
    cfg_write(CfgRandTh, rand_th);
    cfg_write(CfgMinObs, min_obs);
    cfg_write(CfgDepth, depth);
    cfg_write(CfgRecLimit, rec_limit);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering, then wait until every predicted beat has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    logic [IdxW-1:0] walk;
    logic [IdxW-1:0] seq_th;
    logic [IdxW-1:0] rand_th;
    logic [IdxW-1:0] min_obs;
    logic [IdxW-1:0] depth;
    logic [IdxW-1:0] rec_limit;
    int              step;
    int              pick;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    walk          = '0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // ---------------- directed part ----------------

    // reports from the first access on, full-range limit, widest legal depth
    set_config(32'd1, 32'd64, 32'd0, 32'd32, 32'hFFFF_FFFF);
    send_access(32'd0);           // first access, no jump measured, reported as mixed
    send_access(32'd1);           // run, sequential with a full set of predictions
    send_access(32'd2);
    send_access(32'hFFFF_FFF0);   // random jump
    send_access(32'hFFFF_FFF1);   // runs equal three times jumps, still mixed
    send_access(32'hFFFF_FFF2);   // sequential, candidates cut at the limit
    send_access(32'hFFFF_FFFF);   // jump between thresholds, candidate past 32 bits
    send_access(32'd0);           // largest jump
    drain();

    // zero depth, zero run threshold, never-reached thresholds, unused index
    set_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    cfg_write(CfgUnusedIdx, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    send_access(32'd5);
    send_access(32'd5);           // zero jump is a run
    send_access(32'd100);
    send_access(32'hFFFF_FFFF);
    send_access(32'd0);
    drain();

    // every jump is a run, depth above the prediction cap, small record limit
    set_config(32'hFFFF_FFFF, 32'd0, 32'd1, 32'd63, 32'd20);
    send_access(32'd0);
    send_access(32'd3);
    send_access(32'd25);          // beyond the limit, no prediction
    send_access(32'd0);
    drain();
    cfg_write(CfgDepth, 32'd0);   // sequential with zero depth
    cfg_valid_i <= 1'b0;
    send_access(32'd1);
    drain();
    cfg_write(CfgDepth, 32'd63);
    cfg_write(CfgRecLimit, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    send_access(32'd2);           // capped at the prediction maximum
    send_access(32'd3);
    drain();

    // ---------------- random part ----------------
    for (int ph = 0; ph < 8; ph++) begin
      // long stretch with no idling on either side
      no_idle = (ph == 4);

      pick = $urandom_range(0, 9);
      case (pick)
        0:       seq_th = 32'd0;
        7:       seq_th = $urandom_range(9, 1000);
        8:       seq_th = $urandom;
        9:       seq_th = 32'hFFFF_FFFF;
        default: seq_th = $urandom_range(1, 8);
      endcase

      pick = $urandom_range(0, 9);
      case (pick)
        0:       rand_th = 32'd0;
        1:       rand_th = 32'hFFFF_FFFF;
        2:       rand_th = $urandom;
        default: rand_th = (seq_th > 32'hFFFF_FF00) ? seq_th : seq_th + $urandom_range(0, 100);
      endcase

      min_obs = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);

      pick = $urandom_range(0, 9);
      case (pick)
        0:       depth = 32'd0;
        1:       depth = $urandom_range(33, 63);
        default: depth = $urandom_range(1, 32);
      endcase

      // fresh full-width start point half the time
      if ($urandom_range(0, 1) == 0) walk = $urandom;

      pick = $urandom_range(0, 9);
      case (pick)
        0:       rec_limit = 32'd0;
        1:       rec_limit = 32'hFFFF_FFFF;
        2:       rec_limit = $urandom;
        default: rec_limit = walk + $urandom_range(0, 48);
      endcase

      set_config(seq_th, rand_th, min_obs, depth, rec_limit);

      for (int k = 0; k < 20; k++) begin
        // long receiver hold-off with the sender still pushing
        if (ph == 1 && k == 3) hold_req = 1'b1;
        // sender pauses until the block has gone quiet
        if (ph == 2 && k == 10) begin
          s_axis_tvalid <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end

        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          // mostly forward walk within the run threshold
          step = $urandom_range(0, (seq_th < 32'd4) ? int'(seq_th) : 4);
          if ($urandom_range(0, 4) == 0) walk = walk - step;
          else                           walk = walk + step;
        end else if (pick < 88) begin
          walk = $urandom;
        end else begin
          walk = walk + $urandom_range(0, 200);
        end
        send_access(walk);
      end
      drain();
    end
    no_idle = 1'b0;

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
